>>> design/sgf_pkg.sv
// Shared types, constants and functions for the gzip stored-block framer.
// No dependencies; every design file imports this package.
package sgf_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [16:0] MAX_BLOCK_BYTES = 17'd65535;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;

    // Positions in the output byte program: gzip header, stored header, trailer,
    // plus two one-byte runs for data pass-through and error results.
    localparam int unsigned POS_W = 5;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_GZ_FIRST  = 5'd0;
    localparam pos_t POS_GZ_LAST   = 5'd9;
    localparam pos_t POS_BLK_FIRST = 5'd10;
    localparam pos_t POS_BLK_FLAG  = 5'd10;
    localparam pos_t POS_LEN_LO    = 5'd11;
    localparam pos_t POS_LEN_HI    = 5'd12;
    localparam pos_t POS_NLEN_LO   = 5'd13;
    localparam pos_t POS_BLK_LAST  = 5'd14;
    localparam pos_t POS_TRL_FIRST = 5'd15;
    localparam pos_t POS_CRC_LAST  = 5'd18;
    localparam pos_t POS_SIZE_FIRST = 5'd19;
    localparam pos_t POS_TRL_LAST  = 5'd22;
    localparam pos_t POS_DATA      = 5'd23;
    localparam pos_t POS_ERR       = 5'd24;

    localparam logic [7:0] GZ_HEADER [10] = '{
        8'h1f, 8'h8b, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03
    };

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  data_byte;
        logic [15:0] block_length;
        logic        final_block;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       sequence_error;
    } res_t;

    // Everything needed to replay the result bytes of one request
    typedef struct packed {
        pos_t        first_pos;
        pos_t        last_pos;
        logic [7:0]  data_byte;
        logic [15:0] block_length;
        logic        final_block;
        logic [31:0] crc_out;
        logic [31:0] total;
    } run_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

>>> design/sgf_ctrl.sv
// Stream state (CRC, size, block bookkeeping) and per-request run decoding.
// Depends on sgf_pkg.
module sgf_ctrl
    import sgf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    output run_t run
);

    logic [31:0] crc_reg, crc_next;
    logic [31:0] total_reg, total_next;
    logic        header_sent_reg, header_sent_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        final_seen_reg, final_seen_next;

    always_comb
    begin
        crc_next         = crc_reg;
        total_next       = total_reg;
        header_sent_next = header_sent_reg;
        remaining_next   = remaining_reg;
        final_seen_next  = final_seen_reg;

        run.first_pos    = POS_ERR;
        run.last_pos     = POS_ERR;
        run.data_byte    = req.data_byte;
        run.block_length = req.block_length;
        run.final_block  = req.final_block;
        run.crc_out      = ~crc_reg;
        run.total        = total_reg;

        case (req.operation)
            OP_START:
            begin
                if (remaining_reg == 16'd0 && !final_seen_reg
                    && {1'b0, req.block_length} <= MAX_BLOCK_BYTES)
                begin
                    run.first_pos    = header_sent_reg ? POS_BLK_FIRST : POS_GZ_FIRST;
                    run.last_pos     = POS_BLK_LAST;
                    header_sent_next = 1'b1;
                    remaining_next   = req.block_length;
                    final_seen_next  = req.final_block;
                end
            end
            OP_DATA:
            begin
                if (remaining_reg != 16'd0)
                begin
                    run.first_pos  = POS_DATA;
                    run.last_pos   = POS_DATA;
                    crc_next       = crc32_byte(crc_reg, req.data_byte);
                    total_next     = total_reg + 32'd1;
                    remaining_next = remaining_reg - 16'd1;
                end
            end
            OP_FINISH:
            begin
                if (remaining_reg == 16'd0 && !(header_sent_reg && !final_seen_reg))
                begin
                    // no block opened yet: header plus empty final block first
                    run.first_pos    = header_sent_reg ? POS_TRL_FIRST : POS_GZ_FIRST;
                    run.last_pos     = POS_TRL_LAST;
                    run.block_length = 16'd0;
                    run.final_block  = 1'b1;
                    crc_next         = CRC_INIT;
                    total_next       = 32'd0;
                    header_sent_next = 1'b0;
                    remaining_next   = 16'd0;
                    final_seen_next  = 1'b0;
                end
            end
            default:
            begin
                run.first_pos = POS_ERR;
                run.last_pos  = POS_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= CRC_INIT;
            total_reg       <= 32'd0;
            header_sent_reg <= 1'b0;
            remaining_reg   <= 16'd0;
            final_seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            crc_reg         <= crc_next;
            total_reg       <= total_next;
            header_sent_reg <= header_sent_next;
            remaining_reg   <= remaining_next;
            final_seen_reg  <= final_seen_next;
        end
    end

endmodule

>>> design/sgf_emit.sv
// Pending-run skid register, active run and byte sequencer for results.
// Depends on sgf_pkg.
module sgf_emit
    import sgf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  run_t run_in,
    output logic in_ready,
    output logic result_valid,
    input  logic result_ready,
    output res_t result
);

    logic pend_valid_reg;
    run_t pend_reg;
    logic run_valid_reg;
    run_t run_reg;
    pos_t pos_reg;

    logic run_done;
    logic run_free;
    logic take;
    logic [1:0] byte_sel;

    assign run_done = run_valid_reg && result_ready && (pos_reg == run_reg.last_pos);
    assign run_free = !run_valid_reg || run_done;
    assign take     = pend_valid_reg && run_free;
    assign in_ready = !pend_valid_reg || run_free;

    // byte lane within the CRC or size word, least significant first
    assign byte_sel = pos_reg[1:0] + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            run_valid_reg  <= 1'b0;
            pos_reg        <= POS_GZ_FIRST;
        end
        else
        begin
            if (accept)
                pend_valid_reg <= 1'b1;
            else if (take)
                pend_valid_reg <= 1'b0;

            if (take)
            begin
                run_valid_reg <= 1'b1;
                pos_reg       <= pend_reg.first_pos;
            end
            else if (run_done)
                run_valid_reg <= 1'b0;
            else if (run_valid_reg && result_ready)
                pos_reg <= pos_reg + pos_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= run_in;
        if (take)
            run_reg <= pend_reg;
    end

    always_comb
    begin
        result_valid          = run_valid_reg;
        result.last_of_run    = (pos_reg == run_reg.last_pos);
        result.sequence_error = (pos_reg == POS_ERR);
        case (pos_reg) inside
            [POS_GZ_FIRST:POS_GZ_LAST]:  result.out_byte = GZ_HEADER[pos_reg[3:0]];
            POS_BLK_FLAG:                result.out_byte = {7'd0, run_reg.final_block};
            POS_LEN_LO:                  result.out_byte = run_reg.block_length[7:0];
            POS_LEN_HI:                  result.out_byte = run_reg.block_length[15:8];
            POS_NLEN_LO:                 result.out_byte = ~run_reg.block_length[7:0];
            POS_BLK_LAST:                result.out_byte = ~run_reg.block_length[15:8];
            [POS_TRL_FIRST:POS_CRC_LAST]:
                result.out_byte = run_reg.crc_out[{byte_sel, 3'b000} +: 8];
            [POS_SIZE_FIRST:POS_TRL_LAST]:
                result.out_byte = run_reg.total[{byte_sel, 3'b000} +: 8];
            POS_DATA:                    result.out_byte = run_reg.data_byte;
            default:                     result.out_byte = 8'd0;
        endcase
    end

endmodule

>>> design/gzip_stored_block_framer.sv
// Top level of the gzip stored-block framer: request port, state, result port.
// Depends on sgf_pkg, sgf_ctrl and sgf_emit.
//
// Usage:
//   request channel (request_valid/request_ready/request) takes start-block,
//   data-byte and finish requests; result channel (result_valid/result_ready/
//   result) returns the gzip byte stream one byte per transfer, with
//   last_of_run on the final byte of each request and sequence_error on the
//   single result of a misordered request.
//   The first byte of a request goes through the skid register, then the
//   run register, from which it is presented. A request yields 1 to 23
//   result bytes, one per cycle while result_ready is high. Throughput:
//   data-byte requests stream at one per cycle while result_ready is high;
//   a multi-byte request holds the result port until all its bytes are taken.
//   The CRC update and state change are done in the accept cycle, so the
//   next request is never held up by the CRC.
//   Stall: one decoded request waits in a skid register while the result
//   port is stalled; request_ready drops only when that register is full and
//   the current run cannot finish this cycle.
//   Reset: CRC all ones, size zero, no header sent, no block open; the skid
//   and run registers empty.
module gzip_stored_block_framer
    import sgf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic request_valid,
    output logic request_ready,
    input  req_t request,
    output logic result_valid,
    input  logic result_ready,
    output res_t result
);

    logic accept;
    run_t run;

    assign accept = request_valid && request_ready;

    sgf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (request),
        .run    (run)
    );

    sgf_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .run_in       (run),
        .in_ready     (request_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // error results are single zero bytes
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sequence_error |-> result.last_of_run
                                                 && result.out_byte == 8'd0)
        else $error("error result not a single zero byte");

    // back-pressure only while a run is in flight
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !request_ready |-> result_valid)
        else $error("request_ready low with idle result port");

    // a run that ends with result taken and nothing queued leaves port idle
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_of_run && request_ready
        && !request_valid && $past(request_ready) && $past(!request_valid)
        && $past(result_valid) && $past(result.last_of_run) && $past(result_ready)
        |=> !result_valid)
        else $error("result appeared without a request");

endmodule
